[design/totp_pkg.sv]
package totp_pkg;

   localparam int KEY_BYTES_DEFAULT = 20;
   localparam int KEY_BITS = 160;
   localparam int SECS_W = 63;
   localparam int CODE_W = 20;
   localparam int CTR_W = 64;

   localparam logic [CODE_W-1:0] CODE_MODULUS = CODE_W'(1000 * 1000);
   localparam logic [CODE_W-1:0] STEP_SECONDS = CODE_W'(30);

   // Reciprocals rounded down: 2^24 / 30 and 2^40 / 1000000.
   localparam logic [20:0] STEP_RECIP = 21'd559240;
   localparam logic [20:0] CODE_RECIP = 21'd1099511;

   localparam logic [159:0] SHA1_IV =
      {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
   localparam logic [31:0] SHA1_K0 = 32'h5A827999;
   localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
   localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
   localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

   localparam logic [63:0] INNER_LEN_BITS = 64'd576;
   localparam logic [63:0] OUTER_LEN_BITS = 64'd672;
   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5C;
   localparam logic [30:0] TRUNC_MASK = 31'h7FFFFFFF;

   typedef enum logic [1:0] {
      REG_KEY_LOW  = 2'd0,
      REG_KEY_MID  = 2'd1,
      REG_KEY_TAIL = 2'd2,
      REG_WINDOW   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_KEY_INNER = 2'd0,
      PH_CTR       = 2'd1,
      PH_KEY_OUTER = 2'd2,
      PH_DIGEST    = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SET_CTR,
      ST_HASH_GO,
      ST_HASH_WAIT,
      ST_TRUNC,
      ST_MOD_GO,
      ST_MOD_WAIT,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic by_code;
   } div_ctl_type;

endpackage

[design/totp_window_verify.sv]
// Verifies a six-digit TOTP code (HMAC-SHA1, 30-second step) against every time step
// within plus or minus the configured window of the step holding the given time. Each
// word on the request side carries the offered code and the Unix time; one response word
// carries a single accepted bit. The block handles one request at a time and drops
// req_tready while it works. A request first forms the step counter on a reciprocal-multiply
// divider, then for each step tried runs 4 SHA-1 compressions on one shared round unit,
// then truncation, remainder and compare. At most twice the window plus one steps are tried,
// and the search stops at the first match. A response word that is not yet taken holds the
// next result back until it leaves. The user must write key and window registers on the
// csr_ port only while no request is in progress; the block itself does not enforce it.
module totp_window_verify #(
   parameter int KEY_BYTES = totp_pkg::KEY_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [87:0] req_tdata,   // offered_code[19:0], unix_seconds[82:20], zero fill
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,    // accepted[0], zero fill
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [63:0] csr_wdata
);

   totp_pkg::state_type state_ff, state_in;
   totp_pkg::phase_type phase_ff, phase_in;

   logic [63:0] key_low_ff, key_mid_ff;
   logic [31:0] key_tail_ff;
   logic [2:0] window_ff;
   logic [totp_pkg::CODE_W-1:0] code_ff;
   logic [totp_pkg::SECS_W-1:0] secs_ff;
   logic [totp_pkg::CTR_W-1:0] ctr_ff;
   logic [3:0] step_ff;
   logic [159:0] inner_ff;
   logic [30:0] trunc_ff;
   logic rsp_valid_ff;
   logic accepted_ff;
   logic rsp_accepted_ff;

   logic [159:0] key_all;
   logic [159:0] key_masked;
   logic [511:0] key_block;
   logic [511:0] block;
   logic [159:0] h_init;
   logic sha_start, sha_done;
   logic [159:0] digest;
   logic [159:0] digest_shifted;
   logic [7:0] trunc_shift;

   totp_pkg::div_ctl_type div_ctl;
   logic [totp_pkg::SECS_W-1:0] div_dividend;
   logic div_done;
   logic [totp_pkg::SECS_W-1:0] div_quot;
   logic [totp_pkg::CODE_W-1:0] div_rem;

   logic req_take, rsp_free, last_step, match;

   assign req_take = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign last_step = step_ff == {window_ff, 1'b0};
   assign match = div_rem == code_ff;
   assign key_all = {key_low_ff, key_mid_ff, key_tail_ff};

   always_comb begin
      for (int i = 0; i < 20; i++) begin
         key_masked[159 - 8 * i -: 8] = (i < KEY_BYTES) ? key_all[159 - 8 * i -: 8] : 8'h00;
      end
   end

   always_comb begin
      key_block = {key_masked, 352'b0};
      unique case (phase_ff)
         totp_pkg::PH_KEY_INNER: begin
            block = key_block ^ {64{totp_pkg::IPAD}};
            h_init = totp_pkg::SHA1_IV;
         end
         totp_pkg::PH_CTR: begin
            block = {ctr_ff, 8'h80, 376'b0, totp_pkg::INNER_LEN_BITS};
            h_init = digest;
         end
         totp_pkg::PH_KEY_OUTER: begin
            block = key_block ^ {64{totp_pkg::OPAD}};
            h_init = totp_pkg::SHA1_IV;
         end
         default: begin
            block = {inner_ff, 8'h80, 280'b0, totp_pkg::OUTER_LEN_BITS};
            h_init = digest;
         end
      endcase
   end

   assign trunc_shift = 8'd128 - {1'b0, digest[3:0], 3'b000};
   assign digest_shifted = digest >> trunc_shift;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         totp_pkg::ST_IDLE:      if (req_take) state_in = totp_pkg::ST_DIV_GO;
         totp_pkg::ST_DIV_GO:    state_in = totp_pkg::ST_DIV_WAIT;
         totp_pkg::ST_DIV_WAIT:  if (div_done) state_in = totp_pkg::ST_SET_CTR;
         totp_pkg::ST_SET_CTR:   state_in = totp_pkg::ST_HASH_GO;
         totp_pkg::ST_HASH_GO:   state_in = totp_pkg::ST_HASH_WAIT;
         totp_pkg::ST_HASH_WAIT: begin
            if (sha_done) begin
               state_in = (phase_ff == totp_pkg::PH_DIGEST) ? totp_pkg::ST_TRUNC
                                                            : totp_pkg::ST_HASH_GO;
            end
         end
         totp_pkg::ST_TRUNC:     state_in = totp_pkg::ST_MOD_GO;
         totp_pkg::ST_MOD_GO:    state_in = totp_pkg::ST_MOD_WAIT;
         totp_pkg::ST_MOD_WAIT:  if (div_done) state_in = totp_pkg::ST_CHECK;
         totp_pkg::ST_CHECK: begin
            state_in = (match || last_step) ? totp_pkg::ST_DONE : totp_pkg::ST_HASH_GO;
         end
         totp_pkg::ST_DONE:      if (rsp_free) state_in = totp_pkg::ST_IDLE;
         default:                state_in = totp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      req_tready = 1'b0;
      sha_start = 1'b0;
      div_ctl.start = 1'b0;
      div_ctl.by_code = 1'b0;
      div_dividend = secs_ff;
      unique case (state_ff)
         totp_pkg::ST_IDLE:    req_tready = 1'b1;
         totp_pkg::ST_DIV_GO:  div_ctl.start = 1'b1;
         totp_pkg::ST_SET_CTR: phase_in = totp_pkg::PH_KEY_INNER;
         totp_pkg::ST_HASH_GO: sha_start = 1'b1;
         totp_pkg::ST_HASH_WAIT: begin
            if (sha_done) phase_in = totp_pkg::phase_type'(phase_ff + 2'd1);
         end
         totp_pkg::ST_MOD_GO, totp_pkg::ST_MOD_WAIT: begin
            div_ctl.start = state_ff == totp_pkg::ST_MOD_GO;
            div_ctl.by_code = 1'b1;
            div_dividend = {32'b0, trunc_ff};
         end
         default: begin
         end
      endcase
   end

   totp_sha1_round u_round (
      .clock  (clock),
      .reset  (reset),
      .start  (sha_start),
      .h_init (h_init),
      .block  (block),
      .done   (sha_done),
      .digest (digest)
   );

   totp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_ff @(posedge clock) begin
      if (req_take) begin
         code_ff <= req_tdata[19:0];
         secs_ff <= req_tdata[82:20];
      end
      if (state_ff == totp_pkg::ST_SET_CTR) begin
         ctr_ff <= {1'b0, div_quot} - totp_pkg::CTR_W'(window_ff);
         step_ff <= '0;
      end else if (state_ff == totp_pkg::ST_CHECK) begin
         ctr_ff <= ctr_ff + 1'b1;
         step_ff <= step_ff + 1'b1;
      end
      if (state_ff == totp_pkg::ST_HASH_WAIT && sha_done && phase_ff == totp_pkg::PH_CTR) begin
         inner_ff <= digest;
      end
      if (state_ff == totp_pkg::ST_TRUNC) begin
         trunc_ff <= digest_shifted[30:0] & totp_pkg::TRUNC_MASK;
      end
      if (state_ff == totp_pkg::ST_CHECK && (match || last_step)) begin
         accepted_ff <= match;
      end
      if (state_ff == totp_pkg::ST_DONE && rsp_free) begin
         rsp_accepted_ff <= accepted_ff;
      end
      if (reset) begin
         state_ff <= totp_pkg::ST_IDLE;
         phase_ff <= totp_pkg::PH_KEY_INNER;
         rsp_valid_ff <= 1'b0;
         key_low_ff <= '0;
         key_mid_ff <= '0;
         key_tail_ff <= '0;
         window_ff <= 3'd3;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (state_ff == totp_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (totp_pkg::reg_index_type'(csr_index))
               totp_pkg::REG_KEY_LOW:  key_low_ff <= csr_wdata;
               totp_pkg::REG_KEY_MID:  key_mid_ff <= csr_wdata;
               totp_pkg::REG_KEY_TAIL: key_tail_ff <= csr_wdata[31:0];
               totp_pkg::REG_WINDOW:   window_ff <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'b0, rsp_accepted_ff};

`ifndef NO_ASSERTIONS
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("request taken while a check is in progress");

   a_sha_done_waited: assert property (@(posedge clock) disable iff (reset)
      sha_done |-> state_ff == totp_pkg::ST_HASH_WAIT)
      else $error("hash finished outside its wait state");

   a_step_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == totp_pkg::ST_CHECK |-> step_ff <= {window_ff, 1'b0})
      else $error("step beyond the window");
`endif

endmodule

[design/totp_div.sv]
module totp_div (
   input  logic clock,
   input  logic reset,
   input  totp_pkg::div_ctl_type ctl,
   input  logic [totp_pkg::SECS_W-1:0] dividend,
   output logic done,
   output logic [totp_pkg::SECS_W-1:0] quot,
   output logic [totp_pkg::CODE_W-1:0] rem
);

   logic [totp_pkg::SECS_W:0] num_ff, num_in;
   logic [totp_pkg::SECS_W-1:0] quot_ff, quot_in;
   logic [totp_pkg::CODE_W-1:0] rem_ff, rem_in;
   logic [30:0] x_ff, x_in;
   logic [15:0] qd_ff, qd_in;
   logic [2:0] left_ff, left_in;
   logic by_code_ff, by_code_in;
   logic back_ff, back_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [20:0] recip;
   logic [totp_pkg::CODE_W-1:0] divisor;
   logic [51:0] prod;
   logic [15:0] q_est;
   logic [35:0] back;
   logic [31:0] diff;
   logic fix;
   logic [totp_pkg::CODE_W-1:0] rem_next;
   logic [15:0] q_fin;

   // Each 16-bit digit is formed by a reciprocal estimate of the quotient digit,
   // then the remainder with one correction step.
   always_comb begin
      recip = by_code_ff ? totp_pkg::CODE_RECIP : totp_pkg::STEP_RECIP;
      divisor = by_code_ff ? totp_pkg::CODE_MODULUS : totp_pkg::STEP_SECONDS;
      prod = {21'b0, x_ff} * {31'b0, recip};
      q_est = by_code_ff ? {4'b0, prod[51:40]} : prod[39:24];
      back = {20'b0, qd_ff} * {16'b0, divisor};
      diff = {1'b0, x_ff} - back[31:0];
      fix = diff >= {12'b0, divisor};
      rem_next = fix ? diff[totp_pkg::CODE_W-1:0] - divisor : diff[totp_pkg::CODE_W-1:0];
      q_fin = qd_ff + {15'b0, fix};
      num_in = num_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      x_in = x_ff;
      qd_in = qd_ff;
      left_in = left_ff;
      by_code_in = by_code_ff;
      back_in = back_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         num_in = {1'b0, dividend} << 16;
         quot_in = '0;
         rem_in = '0;
         x_in = ctl.by_code ? dividend[30:0] : {16'b0, dividend[totp_pkg::SECS_W-1:48]};
         left_in = ctl.by_code ? 3'd1 : 3'd4;
         by_code_in = ctl.by_code;
         back_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!back_ff) begin
            qd_in = q_est;
            back_in = 1'b1;
         end else begin
            back_in = 1'b0;
            rem_in = rem_next;
            quot_in = {quot_ff[totp_pkg::SECS_W-17:0], q_fin};
            num_in = num_ff << 16;
            x_in = {10'b0, rem_next[4:0], num_ff[totp_pkg::SECS_W:48]};
            left_in = left_ff - 3'd1;
            if (left_ff == 3'd1) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      x_ff <= x_in;
      qd_ff <= qd_in;
      left_ff <= left_in;
      by_code_ff <= by_code_in;
      back_ff <= back_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem = rem_ff;

endmodule

[design/totp_sha1_round.sv]
module totp_sha1_round (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [159:0] h_init,
   input  logic [511:0] block,
   output logic done,
   output logic [159:0] digest
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [159:0] h_ff;
   logic [159:0] digest_ff;
   logic [6:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic fin_ff, fin_in;
   logic done_ff;
   logic [31:0] f, k, sched, tmp;

   always_comb begin
      if (cnt_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = totp_pkg::SHA1_K0;
      end else if (cnt_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = totp_pkg::SHA1_K1;
      end else if (cnt_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = totp_pkg::SHA1_K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = totp_pkg::SHA1_K3;
      end
      tmp = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w_ff[0];
      sched = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   end

   always_comb begin
      w_in = w_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      fin_in = 1'b0;
      if (start) begin
         for (int i = 0; i < 16; i++) begin
            w_in[i] = block[511 - 32 * i -: 32];
         end
         {a_in, b_in, c_in, d_in, e_in} = h_init;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = {sched[30:0], sched[31]};
         a_in = tmp;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 7'd79) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      cnt_ff <= cnt_in;
      if (start) begin
         h_ff <= h_init;
      end
      if (fin_ff) begin
         digest_ff <= {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                       h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
      end
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         done_ff <= fin_ff;
      end
   end

   assign done = done_ff;
   assign digest = digest_ff;

endmodule
